// ===== sv/euler_orbit_integrator_macros.svh =====
// Assertion macros shared by the integrator's RTL
`ifndef EULER_ORBIT_INTEGRATOR_MACROS_SVH
`define EULER_ORBIT_INTEGRATOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define EOI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define EOI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/eoi_pkg.sv =====
// Package: shared types, constants and helpers of the orbit integrator
package eoi_pkg;

  localparam int FRAC_BITS = 32;
  localparam int SW        = 48;
  localparam int DATA_W    = 6 * SW;

  localparam logic [63:0] DAYS_Q32       = 64'd1568702445126;
  localparam logic [63:0] FOUR_PI_SQ_Q32 = 64'd169558512508;

  localparam logic [1:0] CFG_STEP_H     = 2'd0;
  localparam logic [1:0] CFG_STAR_MASS  = 2'd1;
  localparam logic [1:0] CFG_EMIT_EVERY = 2'd2;

  // scaling of the acceleration quotient: 2^(3F-88)
  localparam int SHIFT_E = 3 * FRAC_BITS - 88;
  localparam int NUM_SH  = (SHIFT_E > 0) ? SHIFT_E : 0;
  localparam int DEN_SH  = (SHIFT_E < 0) ? -SHIFT_E : 0;
  localparam int NUM_W   = 150;
  localparam int DEN_W   = 144;
  localparam int DIV_W   = ((NUM_W + NUM_SH > DEN_W + DEN_SH) ?
                            NUM_W + NUM_SH : DEN_W + DEN_SH) + 1;
  localparam int QB      = SW + 1;

  localparam int A_W   = 128;
  localparam int B_W   = 64;
  localparam int ACC_W = A_W + B_W;

  localparam logic [QB-1:0] MAG_CAP = QB'(1) << SW;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_LD_VEL, OP_EMIT, OP_SQ, OP_SQRT, OP_R2, OP_R3,
    OP_HK, OP_HKM, OP_DV, OP_DP, OP_COMMIT
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LD_VEL, ST_EMIT, ST_SQ, ST_SQRT, ST_R2, ST_R3, ST_HK,
    ST_HKM, ST_DV, ST_DP, ST_COMMIT
  } ctl_st_t;

  typedef enum logic [1:0] {DV_IDLE, DV_CHK, DV_RUN} div_st_t;

  typedef struct packed {
    logic       go;
    dp_op_t     op;
    logic [1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic rad_zero;
  } dp_sts_t;

  // ops that run over several cycles and report completion later
  function automatic logic is_multi(dp_op_t op);
    return !(op == OP_NONE || op == OP_LOAD || op == OP_EMIT || op == OP_COMMIT);
  endfunction

endpackage

// ===== sv/eoi_mul.sv =====
// Multi-cycle multiplier: one 32x32 limb product per cycle into an accumulator
module eoi_mul (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [eoi_pkg::A_W-1:0]   a,
  input  logic [eoi_pkg::B_W-1:0]   b,
  input  logic [1:0]                na,
  input  logic                      nb,
  output logic                      done,
  output logic [eoi_pkg::ACC_W-1:0] prod
);

  logic [eoi_pkg::A_W-1:0]   a_r;
  logic [eoi_pkg::B_W-1:0]   b_r;
  logic [1:0]                na_r, ia_r;
  logic                      nb_r, ib_r;
  logic                      busy_r, done_r;
  logic [eoi_pkg::ACC_W-1:0] acc_r;

  logic [31:0]               la, lb;
  logic [63:0]               pp;
  logic [2:0]                sh;
  logic [eoi_pkg::ACC_W-1:0] addend;

  always_comb begin
    la     = a_r[32*ia_r +: 32];
    lb     = b_r[32*ib_r +: 32];
    pp     = la * lb;
    sh     = 3'(ia_r) + 3'(ib_r);
    addend = eoi_pkg::ACC_W'(pp) << {sh, 5'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && busy_r && ib_r == nb_r && ia_r == na_r;
      if (start) begin
        a_r    <= a;
        b_r    <= b;
        na_r   <= na;
        nb_r   <= nb;
        ia_r   <= 2'd0;
        ib_r   <= 1'b0;
        acc_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= acc_r + addend;
        if (ib_r == nb_r) begin
          ib_r <= 1'b0;
          if (ia_r == na_r) begin
            busy_r <= 1'b0;
          end else begin
            ia_r <= ia_r + 2'd1;
          end
        end else begin
          ib_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== sv/eoi_div.sv =====
// Rounded restoring divider for the acceleration term, one quotient bit a cycle
module eoi_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [eoi_pkg::NUM_W-1:0] num,
  input  logic [eoi_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [eoi_pkg::QB-1:0]    q
);

  eoi_pkg::div_st_t            st_r, st_nxt;
  logic [eoi_pkg::DIV_W-1:0]   n_r, d_r, rem_r, trial, dsh;
  logic [eoi_pkg::QB-1:0]      nlo_r, q_r;
  logic [5:0]                  cnt_r;
  logic                        ovf_r, done_r, ge, last_bit;

  always_comb begin
    dsh      = eoi_pkg::DIV_W'(den) << eoi_pkg::DEN_SH;
    trial    = {rem_r[eoi_pkg::DIV_W-2:0], nlo_r[eoi_pkg::QB-1]};
    ge       = trial >= d_r;
    last_bit = cnt_r == 6'(eoi_pkg::QB - 1);
    st_nxt   = st_r;
    unique case (st_r)
      eoi_pkg::DV_IDLE: if (start) st_nxt = eoi_pkg::DV_CHK;
      eoi_pkg::DV_CHK:  st_nxt = eoi_pkg::DV_RUN;
      eoi_pkg::DV_RUN:  if (last_bit) st_nxt = eoi_pkg::DV_IDLE;
      default:          st_nxt = eoi_pkg::DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= eoi_pkg::DV_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= st_r == eoi_pkg::DV_RUN && last_bit;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      eoi_pkg::DV_IDLE: begin
        if (start) begin
          // adding half the divisor makes the floor a round-to-nearest
          n_r <= (eoi_pkg::DIV_W'(num) << eoi_pkg::NUM_SH) + (dsh >> 1);
          d_r <= dsh;
        end
      end
      eoi_pkg::DV_CHK: begin
        rem_r <= n_r >> eoi_pkg::QB;
        nlo_r <= n_r[eoi_pkg::QB-1:0];
        ovf_r <= (n_r >> eoi_pkg::QB) >= d_r;
        q_r   <= '0;
        cnt_r <= '0;
      end
      eoi_pkg::DV_RUN: begin
        rem_r <= ge ? trial - d_r : trial;
        q_r   <= {q_r[eoi_pkg::QB-2:0], ge};
        nlo_r <= nlo_r << 1;
        cnt_r <= cnt_r + 6'd1;
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign q    = (ovf_r || q_r > eoi_pkg::MAG_CAP) ? eoi_pkg::MAG_CAP : q_r;

endmodule

// ===== sv/eoi_dp.sv =====
// Datapath: state, configuration, square root, multiplier and divider
module eoi_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  input  logic [1:0]                 cfg_index,
  input  logic [31:0]                cfg_data,
  input  logic [eoi_pkg::DATA_W-1:0] in_tdata,
  input  eoi_pkg::dp_cmd_t           cmd,
  output eoi_pkg::dp_sts_t           sts,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [eoi_pkg::DATA_W-1:0] out_tdata
);

  localparam int SW = eoi_pkg::SW;

  logic [SW-1:0] pos_r [3];
  logic [SW-1:0] vel_r [3];
  logic [SW-1:0] lv_r [3];
  logic [SW-1:0] newv_r [3];
  logic [31:0]   step_h_r, mass_r;
  logic [15:0]   every_r, phase_r;

  logic [95:0]   r2_r, tmp_r, sq_src_r;
  logic [143:0]  den_r;
  logic [101:0]  hkm_r;
  logic [SW-1:0] rad_r, sq_root_r;
  logic [49:0]   sq_rem_r;
  logic [5:0]    sq_cnt_r;
  logic          sq_busy_r, sq_done_r;

  eoi_pkg::dp_op_t op_r;
  logic [1:0]    idx_r;
  logic          mul_go_r;
  logic          out_valid_r;
  logic [eoi_pkg::DATA_W-1:0] out_data_r;

  logic [eoi_pkg::A_W-1:0]   mul_a;
  logic [eoi_pkg::B_W-1:0]   mul_b;
  logic [1:0]                mul_na;
  logic                      mul_nb, mul_done;
  logic [eoi_pkg::ACC_W-1:0] mul_prod, rnd;
  logic [eoi_pkg::QB-1:0]    rq, div_q;
  logic                      div_done, div_go;
  logic [SW-1:0]             pm;
  logic                      emit_ok, load_go, commit_go;
  logic [15:0]               every;
  logic [16:0]               ph1;
  logic [51:0]               sq_rt, sq_trial;
  logic                      sq_ge;

  function automatic logic [SW-1:0] mag48(logic [SW-1:0] p);
    return p[SW-1] ? (~p + SW'(1)) : p;
  endfunction

  // old +/- magnitude, saturated to the signed 48-bit range
  function automatic logic [SW-1:0] sat_apply(logic [SW-1:0] old,
                                              logic [eoi_pkg::QB-1:0] m, logic sub);
    logic [SW+2:0] s, r;
    s = {{3{old[SW-1]}}, old};
    r = sub ? s - (SW+3)'(m) : s + (SW+3)'(m);
    if (r[SW+2:SW-1] == '0 || r[SW+2:SW-1] == '1) return r[SW-1:0];
    else if (r[SW+2]) return {1'b1, {(SW-1){1'b0}}};
    else return {1'b0, {(SW-1){1'b1}}};
  endfunction

  eoi_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_go_r), .a(mul_a), .b(mul_b),
    .na(mul_na), .nb(mul_nb), .done(mul_done), .prod(mul_prod)
  );

  assign div_go = mul_done && op_r == eoi_pkg::OP_DV;

  eoi_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go),
    .num(mul_prod[eoi_pkg::NUM_W-1:0]), .den(den_r),
    .done(div_done), .q(div_q)
  );

  always_comb begin
    pm     = mag48(pos_r[idx_r]);
    mul_a  = '0;
    mul_b  = '0;
    mul_na = 2'd1;
    mul_nb = 1'b1;
    unique case (op_r)
      eoi_pkg::OP_LD_VEL: begin
        mul_a = eoi_pkg::A_W'(mag48(lv_r[idx_r]));
        mul_b = eoi_pkg::DAYS_Q32;
      end
      eoi_pkg::OP_SQ: begin
        mul_a = eoi_pkg::A_W'(pm);
        mul_b = eoi_pkg::B_W'(pm);
      end
      eoi_pkg::OP_R2: begin
        mul_a = eoi_pkg::A_W'(rad_r);
        mul_b = eoi_pkg::B_W'(rad_r);
      end
      eoi_pkg::OP_R3: begin
        mul_a  = eoi_pkg::A_W'(tmp_r);
        mul_b  = eoi_pkg::B_W'(rad_r);
        mul_na = 2'd2;
      end
      eoi_pkg::OP_HK: begin
        mul_a  = eoi_pkg::A_W'(eoi_pkg::FOUR_PI_SQ_Q32);
        mul_b  = eoi_pkg::B_W'(step_h_r);
        mul_nb = 1'b0;
      end
      eoi_pkg::OP_HKM: begin
        mul_a  = eoi_pkg::A_W'(tmp_r);
        mul_b  = eoi_pkg::B_W'(mass_r);
        mul_na = 2'd2;
        mul_nb = 1'b0;
      end
      eoi_pkg::OP_DV: begin
        mul_a  = eoi_pkg::A_W'(hkm_r);
        mul_b  = eoi_pkg::B_W'(pm);
        mul_na = 2'd3;
      end
      eoi_pkg::OP_DP: begin
        mul_a  = eoi_pkg::A_W'(mag48(vel_r[idx_r]));
        mul_b  = eoi_pkg::B_W'(step_h_r);
        mul_nb = 1'b0;
      end
      default: ;
    endcase

    // round(prod / 2^32), capped at 2^48
    rnd = mul_prod + eoi_pkg::ACC_W'(33'h0_8000_0000);
    if (|rnd[eoi_pkg::ACC_W-1:32+eoi_pkg::QB]) rq = eoi_pkg::MAG_CAP;
    else if (rnd[32 +: eoi_pkg::QB] > eoi_pkg::MAG_CAP) rq = eoi_pkg::MAG_CAP;
    else rq = rnd[32 +: eoi_pkg::QB];

    every     = (every_r == 16'd0) ? 16'd1 : every_r;
    ph1       = {1'b0, phase_r} + 17'd1;
    emit_ok   = cmd.go && cmd.op == eoi_pkg::OP_EMIT &&
                (phase_r != 16'd0 || !out_valid_r || out_tready);
    load_go   = cmd.go && cmd.op == eoi_pkg::OP_LOAD;
    commit_go = cmd.go && cmd.op == eoi_pkg::OP_COMMIT;

    sq_rt    = {sq_rem_r, sq_src_r[95:94]};
    sq_trial = 52'({sq_root_r, 2'b01});
    sq_ge    = sq_rt >= sq_trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        vel_r[i] <= '0;
      end
      step_h_r    <= 32'd42950;
      mass_r      <= 32'd16777216;
      every_r     <= 16'd50;
      phase_r     <= '0;
      op_r        <= eoi_pkg::OP_NONE;
      idx_r       <= '0;
      mul_go_r    <= 1'b0;
      sq_busy_r   <= 1'b0;
      sq_done_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mul_go_r  <= cmd.go && eoi_pkg::is_multi(cmd.op) && cmd.op != eoi_pkg::OP_SQRT;
      sq_done_r <= sq_busy_r && sq_cnt_r == 6'(SW - 1);

      if (cfg_valid) begin
        unique case (cfg_index)
          eoi_pkg::CFG_STEP_H:     step_h_r <= cfg_data;
          eoi_pkg::CFG_STAR_MASS:  mass_r   <= cfg_data;
          eoi_pkg::CFG_EMIT_EVERY: every_r  <= cfg_data[15:0];
          default: ;
        endcase
      end

      if (cmd.go && eoi_pkg::is_multi(cmd.op)) begin
        op_r  <= cmd.op;
        idx_r <= cmd.idx;
        if (cmd.op == eoi_pkg::OP_SQRT) begin
          sq_busy_r <= 1'b1;
          sq_src_r  <= r2_r;
          sq_rem_r  <= '0;
          sq_root_r <= '0;
          sq_cnt_r  <= '0;
        end
      end

      if (load_go) begin
        for (int i = 0; i < 3; i++) begin
          pos_r[i] <= in_tdata[SW*i +: SW];
          lv_r[i]  <= in_tdata[SW*(i+3) +: SW];
        end
        phase_r <= '0;
      end

      if (emit_ok && phase_r == 16'd0) begin
        out_valid_r <= 1'b1;
        out_data_r  <= {vel_r[2], vel_r[1], vel_r[0], pos_r[2], pos_r[1], pos_r[0]};
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (emit_ok) phase_r <= (ph1 >= {1'b0, every}) ? 16'd0 : ph1[15:0];

      if (commit_go) begin
        for (int i = 0; i < 3; i++) vel_r[i] <= newv_r[i];
      end

      // digit-by-digit square root, two radicand bits a cycle
      if (sq_busy_r) begin
        sq_src_r <= sq_src_r << 2;
        sq_rem_r <= sq_ge ? 50'(sq_rt - sq_trial) : 50'(sq_rt);
        sq_root_r <= {sq_root_r[SW-2:0], sq_ge};
        sq_cnt_r <= sq_cnt_r + 6'd1;
        if (sq_cnt_r == 6'(SW - 1)) begin
          sq_busy_r <= 1'b0;
          rad_r     <= {sq_root_r[SW-2:0], sq_ge};
        end
      end

      if (mul_done) begin
        unique case (op_r)
          eoi_pkg::OP_LD_VEL: vel_r[idx_r] <= sat_apply('0, rq, lv_r[idx_r][SW-1]);
          eoi_pkg::OP_SQ:     r2_r  <= ((idx_r == 2'd0) ? 96'd0 : r2_r) + mul_prod[95:0];
          eoi_pkg::OP_R2:     tmp_r <= mul_prod[95:0];
          eoi_pkg::OP_R3:     den_r <= mul_prod[143:0];
          eoi_pkg::OP_HK:     tmp_r <= mul_prod[95:0];
          eoi_pkg::OP_HKM:    hkm_r <= mul_prod[101:0];
          eoi_pkg::OP_DP:
            pos_r[idx_r] <= sat_apply(pos_r[idx_r], rq, vel_r[idx_r][SW-1]);
          default: ;
        endcase
      end

      // acceleration pulls towards the star: against the sign of the position
      if (div_done)
        newv_r[idx_r] <= sat_apply(vel_r[idx_r], div_q, !pos_r[idx_r][SW-1]);
    end
  end

  assign sts.done     = emit_ok || load_go || commit_go || sq_done_r || div_done ||
                        (mul_done && op_r != eoi_pkg::OP_DV);
  assign sts.rad_zero = rad_r == '0;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;

endmodule

// ===== sv/eoi_ctrl.sv =====
// Controller: sequences the datapath operations of a load or an advance
module eoi_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tuser,
  output logic             in_tready,
  output eoi_pkg::dp_cmd_t cmd,
  input  eoi_pkg::dp_sts_t sts
);

  eoi_pkg::ctl_st_t state_r, state_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             issued_r, issued_nxt;
  eoi_pkg::ctl_st_t after;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= eoi_pkg::ST_IDLE;
      cnt_r    <= '0;
      issued_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      issued_r <= issued_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    issued_nxt = issued_r;
    in_tready  = 1'b0;
    cmd.go     = !issued_r;
    cmd.idx    = cnt_r;
    cmd.op     = eoi_pkg::OP_NONE;
    after      = eoi_pkg::ST_IDLE;

    unique case (state_r)
      eoi_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.op    = eoi_pkg::OP_LOAD;
        cmd.go    = in_tvalid && !in_tuser;
        if (in_tvalid) state_nxt = in_tuser ? eoi_pkg::ST_EMIT : eoi_pkg::ST_LD_VEL;
      end
      eoi_pkg::ST_LD_VEL: begin cmd.op = eoi_pkg::OP_LD_VEL; after = eoi_pkg::ST_IDLE; end
      eoi_pkg::ST_EMIT:   begin cmd.op = eoi_pkg::OP_EMIT;   after = eoi_pkg::ST_SQ;   end
      eoi_pkg::ST_SQ:     begin cmd.op = eoi_pkg::OP_SQ;     after = eoi_pkg::ST_SQRT; end
      eoi_pkg::ST_SQRT: begin
        cmd.op = eoi_pkg::OP_SQRT;
        after  = sts.rad_zero ? eoi_pkg::ST_DP : eoi_pkg::ST_R2;
      end
      eoi_pkg::ST_R2:     begin cmd.op = eoi_pkg::OP_R2;     after = eoi_pkg::ST_R3;  end
      eoi_pkg::ST_R3:     begin cmd.op = eoi_pkg::OP_R3;     after = eoi_pkg::ST_HK;  end
      eoi_pkg::ST_HK:     begin cmd.op = eoi_pkg::OP_HK;     after = eoi_pkg::ST_HKM; end
      eoi_pkg::ST_HKM:    begin cmd.op = eoi_pkg::OP_HKM;    after = eoi_pkg::ST_DV;  end
      eoi_pkg::ST_DV:     begin cmd.op = eoi_pkg::OP_DV;     after = eoi_pkg::ST_DP;  end
      eoi_pkg::ST_DP: begin
        cmd.op = eoi_pkg::OP_DP;
        // a body at the origin keeps its velocity: nothing to commit
        after  = sts.rad_zero ? eoi_pkg::ST_IDLE : eoi_pkg::ST_COMMIT;
      end
      eoi_pkg::ST_COMMIT: begin cmd.op = eoi_pkg::OP_COMMIT; after = eoi_pkg::ST_IDLE; end
      default: state_nxt = eoi_pkg::ST_IDLE;
    endcase

    if (state_r != eoi_pkg::ST_IDLE) begin
      if (sts.done) begin
        issued_nxt = 1'b0;
        // per-axis ops run three times
        if ((state_r == eoi_pkg::ST_LD_VEL || state_r == eoi_pkg::ST_SQ ||
             state_r == eoi_pkg::ST_DV || state_r == eoi_pkg::ST_DP) && cnt_r != 2'd2) begin
          cnt_nxt = cnt_r + 2'd1;
        end else begin
          cnt_nxt   = '0;
          state_nxt = after;
        end
      end else if (cmd.go && eoi_pkg::is_multi(cmd.op)) begin
        issued_nxt = 1'b1;
      end
    end
  end

endmodule

// ===== sv/euler_orbit_integrator.sv =====
// Top level: forward Euler two-body orbit integrator
//
//   channel | direction | words
//   in_     | sink      | cmd in tuser; load position and velocity in tdata
//   out_    | source    | state before the step, one word per emitted step
//   cfg_    | sink      | register index and data, always ready
//
// In an advance the three rounded divisions (49 quotient bits each, with their
// product) and the 48-step square root dominate; with the body at the origin
// the divisions are skipped. The rest is the shared 32x32 limb multiplier. One
// word is worked on at a time. A result waits in the output register and the
// next word is still taken, but an advance that has to emit waits in its emit
// step until that register is free. Reset is synchronous, active low.
`include "euler_orbit_integrator_macros.svh"

module euler_orbit_integrator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic                       in_tuser,   // [0] cmd
  // [47:0] load_x, [95:48] load_y, [143:96] load_z,
  // [191:144] load_vx, [239:192] load_vy, [287:240] load_vz
  input  logic [eoi_pkg::DATA_W-1:0] in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [47:0] pos_x, [95:48] pos_y, [143:96] pos_z,
  // [191:144] vel_x, [239:192] vel_y, [287:240] vel_z
  output logic [eoi_pkg::DATA_W-1:0] out_tdata,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [31:0]                cfg_data
);

  eoi_pkg::dp_cmd_t cmd;
  eoi_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  eoi_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tuser(in_tuser),
    .in_tready(in_tready), .cmd(cmd), .sts(sts)
  );

  eoi_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_tdata(in_tdata), .cmd(cmd), .sts(sts),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  `EOI_ASSERT_NEXT(a_busy_after_word, in_tvalid && in_tready, !in_tready, "sink ready right after a word")
  `EOI_ASSERT_SAME(a_emit_while_busy, $rose(out_tvalid), !in_tready, "result raised while idle")
  `EOI_ASSERT_NEXT(a_load_silent, in_tvalid && in_tready && !in_tuser, !$rose(out_tvalid), "load produced a result")

endmodule
